// ===== rtl/smap_pkg.sv =====
package smap_pkg;

  localparam logic [1:0] KIND_GET = 2'd0;
  localparam logic [1:0] KIND_SET = 2'd1;
  localparam logic [1:0] KIND_DEL = 2'd2;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_LIVE  = 2'd1,
    TAG_TOMB  = 2'd2
  } tag_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic probe;
    logic commit;
  } smap_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic probe_done;
    logic out_free;
  } smap_sts_t;

endpackage

// ===== rtl/smap_ram.sv =====
module smap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/smap_ctrl.sv =====
module smap_ctrl import smap_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  smap_sts_t sts,
  output smap_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_FIN
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      case (state_r)
        ST_CLEAR: if (sts.clear_last) state_r <= ST_IDLE;
        ST_IDLE:  if (in_valid) state_r <= ST_PROBE;
        ST_PROBE: if (sts.probe_done) state_r <= ST_FIN;
        ST_FIN:   if (sts.out_free) state_r <= ST_IDLE;
        default:  state_r <= ST_CLEAR;
      endcase
    end
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign cmd.clear  = (state_r == ST_CLEAR);
  assign cmd.accept = (state_r == ST_IDLE) && in_valid;
  assign cmd.probe  = (state_r == ST_PROBE);
  assign cmd.commit = (state_r == ST_FIN) && sts.out_free;

endmodule

// ===== rtl/smap_dp.sv =====
module smap_dp import smap_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  smap_cmd_t   cmd,
  output smap_sts_t   sts,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_key_id,
  input  logic [31:0] in_key_hash,
  input  logic [31:0] in_new_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [31:0] out_value_out,
  output logic        out_status
);

  localparam int AW        = $clog2(SLOTS);
  localparam int OCC_LIMIT = (SLOTS * 5 + 7) / 8;

  logic [1:0]    kind_r;
  logic [31:0]   key_r;
  logic [31:0]   nval_r;
  logic [AW-1:0] addr_r;
  logic [AW-1:0] cnt_r;
  logic          tomb_seen_r;
  logic [AW-1:0] tomb_idx_r;
  logic          found_r;
  logic          usable_r;
  logic          tgt_tomb_r;
  logic [AW-1:0] tgt_r;
  logic [31:0]   rdval_r;
  logic [AW-1:0] clr_r;
  logic [AW:0]   occ_r;
  logic          out_valid_r;
  logic          out_hit_r;
  logic [31:0]   out_value_r;
  logic          out_status_r;

  logic [AW-1:0] rd_addr;
  logic [1:0]    tag_q;
  logic [31:0]   key_q;
  logic [31:0]   val_q;
  logic          is_live;
  logic          is_tomb;
  logic          is_empty;
  logic          match;
  logic          last;
  logic          at_limit;
  logic          set_new;
  logic          set_ok;
  logic          del_hit;
  logic          tag_we;
  logic [AW-1:0] tag_waddr;
  logic [1:0]    tag_wdata;
  logic          res_hit;
  logic [31:0]   res_value;
  logic          res_status;

  assign rd_addr = cmd.accept ? in_key_hash[AW-1:0] : AW'(addr_r + 1'b1);

  assign is_live  = (tag_q == TAG_LIVE);
  assign is_tomb  = (tag_q == TAG_TOMB);
  assign is_empty = !is_live && !is_tomb;
  assign match    = is_live && (key_q == key_r);
  assign last     = &cnt_r;

  assign at_limit = (occ_r >= (AW + 1)'(OCC_LIMIT));
  assign set_new  = (kind_r == KIND_SET) && !found_r;
  assign set_ok   = set_new && usable_r && !at_limit;
  assign del_hit  = (kind_r == KIND_DEL) && found_r;

  assign tag_we    = cmd.clear || (cmd.commit && (set_ok || del_hit));
  assign tag_waddr = cmd.clear ? clr_r : tgt_r;
  assign tag_wdata = cmd.clear ? TAG_EMPTY : (set_ok ? TAG_LIVE : TAG_TOMB);

  smap_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (rd_addr),
    .rdata (tag_q)
  );

  smap_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (cmd.commit && set_ok),
    .waddr (tgt_r),
    .wdata (key_r),
    .raddr (rd_addr),
    .rdata (key_q)
  );

  smap_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_val_ram (
    .clk   (clk),
    .we    (cmd.commit && (set_ok || ((kind_r == KIND_SET) && found_r))),
    .waddr (tgt_r),
    .wdata (nval_r),
    .raddr (rd_addr),
    .rdata (val_q)
  );

  always_comb begin
    res_hit    = 1'b0;
    res_value  = '0;
    res_status = 1'b0;
    case (kind_r)
      KIND_GET: begin
        res_hit   = found_r;
        res_value = found_r ? rdval_r : '0;
      end
      KIND_SET: begin
        res_hit    = set_ok;
        res_status = set_new && !set_ok;
      end
      KIND_DEL: begin
        res_hit   = found_r;
        res_value = found_r ? rdval_r : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_r <= AW'(clr_r + 1'b1);
      end
      if (cmd.commit && set_ok && !tgt_tomb_r) begin
        occ_r <= occ_r + 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r      <= in_kind;
      key_r       <= in_key_id;
      nval_r      <= in_new_value;
      addr_r      <= in_key_hash[AW-1:0];
      cnt_r       <= '0;
      tomb_seen_r <= 1'b0;
      found_r     <= 1'b0;
      usable_r    <= 1'b0;
    end
    if (cmd.probe) begin
      addr_r <= AW'(addr_r + 1'b1);
      cnt_r  <= AW'(cnt_r + 1'b1);
      if (match) begin
        found_r <= 1'b1;
        tgt_r   <= addr_r;
        rdval_r <= val_q;
      end else if (is_empty) begin
        usable_r   <= 1'b1;
        tgt_r      <= tomb_seen_r ? tomb_idx_r : addr_r;
        tgt_tomb_r <= tomb_seen_r;
      end else begin
        if (is_tomb && !tomb_seen_r) begin
          tomb_seen_r <= 1'b1;
          tomb_idx_r  <= addr_r;
        end
        if (last) begin
          usable_r   <= tomb_seen_r || is_tomb;
          tgt_r      <= tomb_seen_r ? tomb_idx_r : addr_r;
          tgt_tomb_r <= 1'b1;
        end
      end
    end
    if (cmd.commit) begin
      out_hit_r    <= res_hit;
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign sts.clear_last = &clr_r;
  assign sts.probe_done = match || is_empty || last;
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;

endmodule

// ===== rtl/symbol_map_linear_probe_table_top.sv =====
// Symbol map: fixed-size open-addressing table, 32-bit key id to 32-bit value,
// linear probing with tombstones.
// Input channel (in_*): one request word per accept, kind get/set/delete,
// key id, key hash (low log2(SLOTS) bits pick the first slot), new value.
// Result channel (out_*): exactly one result word per request, in order:
// hit, value_out, status (1 = set refused at 5/8 load or no free slot).
// Each request probes P slots (1..SLOTS), one slot per cycle through the
// key/tag/value RAM read port, before its result is loaded into the output
// register. A new request is taken only once the previous result has been
// loaded there, so requests are handled one at a time and never overlap.
// Reset (rst_n low, synchronous) starts a sweep through all SLOTS slots that
// marks every slot empty; in_stall stays high during the sweep.
// A stalled result holds in the output register; the next request may be
// accepted and probed meanwhile, and waits to finish until the register
// frees up.
module symbol_map_linear_probe_table_top import smap_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_key_id,
  input  logic [31:0] in_key_hash,
  input  logic [31:0] in_new_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [31:0] out_value_out,
  output logic        out_status
);

  smap_cmd_t cmd;
  smap_sts_t sts;

  smap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  smap_dp #(.SLOTS(SLOTS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (in_kind),
    .in_key_id     (in_key_id),
    .in_key_hash   (in_key_hash),
    .in_new_value  (in_new_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_value_out (out_value_out),
    .out_status    (out_status)
  );

endmodule

// ===== rtl/smap_chk.sv =====
module smap_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic [31:0] out_value_out,
  input logic        out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) &&
      $stable(out_value_out) && $stable(out_status))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one in flight");

  a_refuse_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_hit && out_value_out == 32'd0)
    else $error("refused set reports hit or value");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_value_out == 32'd0)
    else $error("miss returns nonzero value");

endmodule

bind symbol_map_linear_probe_table_top smap_chk u_smap_chk (.*);
